@@ src/quintic_trajectory_interpolator_top_assert.svh @@
// ----------------------------------------------------------------------------
// qti assertion macros
// concurrent checks on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef QUINTIC_TRAJECTORY_INTERPOLATOR_TOP_ASSERT_SVH
`define QUINTIC_TRAJECTORY_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define QTI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qti check failed");
`define QTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qti check failed");
`else
`define QTI_ASSERT_NOW(lbl, ante, cons)
`define QTI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/qti_pkg.sv @@
// ----------------------------------------------------------------------------
// qti_pkg
// shared types, constants and fixed point helpers of the quintic interpolator
// ----------------------------------------------------------------------------
package qti_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int AXES_DEF       = 3;

    localparam logic [11:0] SEG_TICKS_RST    = 12'd10;
    localparam logic [31:0] SEG_TIME_RST     = 32'd42949673;
    localparam logic [31:0] INV_SEG_TIME_RST = 32'd6553600;
    localparam logic [31:0] TICK_TIME_RST    = 32'd4294967;

    localparam logic [30:0] ONE_U      = 31'h4000_0000;
    localparam int          STEP_SHIFT = 18;
    localparam int          U_FRAC     = 30;
    localparam int          INV_FRAC   = 16;
    localparam int          SEG_FRAC   = 32;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic signed [47:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] Q48_MIN = 48'sh8000_0000_0000;

    typedef logic signed [47:0] q48_t;

    typedef enum logic [1:0] {
        CFG_SEG_TICKS,
        CFG_SEG_TIME,
        CFG_INV_SEG_TIME,
        CFG_TICK_TIME
    } cfg_idx_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_STEP,
        T_U,
        T_START,
        T_WAIT
    } top_state_t;

    typedef enum logic [3:0] {
        L_IDLE,
        L_RING0,
        L_RING1,
        L_RING2,
        L_INIT,
        L_MUL_LO,
        L_MUL_HI,
        L_POST,
        L_BUILD5,
        L_BUILD4,
        L_BUILD3
    } lane_state_t;

    typedef enum logic [2:0] {
        PH_POS,
        PH_VEL,
        PH_ACC,
        PH_D,
        PH_T,
        PH_DD
    } phase_t;

    typedef struct packed {
        logic start;
        logic new_seg;
        logic have;
        logic wr_en;
    } lane_ctrl_t;

    function automatic q48_t sat48(input logic signed [79:0] x);
        if (x[79:47] == {33{x[47]}}) begin
            return x[47:0];
        end
        return x[79] ? Q48_MIN : Q48_MAX;
    endfunction

    function automatic q48_t scale_coef(input q48_t c, input logic [4:0] f);
        logic signed [79:0] cx;
        cx = 80'(c);
        case (f)
            5'd2:    return sat48(cx * 80'sd2);
            5'd3:    return sat48(cx * 80'sd3);
            5'd4:    return sat48(cx * 80'sd4);
            5'd5:    return sat48(cx * 80'sd5);
            5'd6:    return sat48(cx * 80'sd6);
            5'd12:   return sat48(cx * 80'sd12);
            5'd20:   return sat48(cx * 80'sd20);
            default: return c;
        endcase
    endfunction

    function automatic logic [4:0] coef_factor(input phase_t ph, input logic [2:0] k);
        case (ph)
            PH_VEL: return 5'(k) + 5'd1;
            PH_ACC: begin
                case (k)
                    3'd0:    return 5'd2;
                    3'd1:    return 5'd6;
                    3'd2:    return 5'd12;
                    default: return 5'd20;
                endcase
            end
            default: return 5'd1;
        endcase
    endfunction

    function automatic logic [2:0] coef_offset(input phase_t ph);
        case (ph)
            PH_VEL:  return 3'd1;
            PH_ACC:  return 3'd2;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] horner_top(input phase_t ph);
        case (ph)
            PH_VEL:  return 3'd4;
            PH_ACC:  return 3'd3;
            default: return 3'd5;
        endcase
    endfunction

endpackage

@@ src/qti_lane.sv @@
// ----------------------------------------------------------------------------
// qti_lane
// one axis: waypoint ring, coefficient store and a sequenced horner engine
// around one 48x32 multiplier with its low and high parts in separate cycles
// ----------------------------------------------------------------------------
module qti_lane
    import qti_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lane_ctrl_t                    ctrl,
    input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
    input  logic [31:0]                   wr_data,
    input  logic [$clog2(RING_DEPTH)-1:0] i1,
    input  logic [$clog2(RING_DEPTH)-1:0] i2,
    input  logic [30:0]                   u,
    input  logic [31:0]                   seg_time,
    input  logic [31:0]                   inv_seg_time,
    output logic                          idle,
    output q48_t                          pos,
    output q48_t                          vel,
    output q48_t                          acc
);

    localparam int IDX_W = $clog2(RING_DEPTH);

    logic [31:0]      ring_mem [RING_DEPTH];
    logic [31:0]      rd_reg;
    logic [IDX_W-1:0] rd_addr;

    lane_state_t state_reg, state_next;
    phase_t      ph_reg, ph_next;
    logic        hor_reg, hor_next;
    logic        scnt_reg, scnt_next;
    logic        end_reg, end_next;
    logic [2:0]  idx_reg, idx_next;

    q48_t acc_reg, acc_next;
    q48_t p_reg, p_next;
    q48_t v_reg, v_next;
    q48_t a_reg, a_next;
    q48_t d_reg, d_next;
    q48_t dd_reg, dd_next;
    logic signed [31:0] se_reg, se_next;
    logic signed [31:0] s2_reg, s2_next;
    q48_t coef_reg [6];
    q48_t coef_next [6];

    logic [47:0]        plo_reg;
    logic signed [79:0] prod_reg;
    logic signed [64:0] phi;
    logic [31:0]        mul_w;

    logic [2:0]         kidx;
    logic [2:0]         cidx;
    q48_t               kval;
    logic signed [79:0] shv;
    q48_t               shs;
    q48_t               post_val;

    logic signed [79:0] s0x, dx, ddx, diffx, ex;
    logic signed [79:0] b5, b4, b3;

    // ring
    assign rd_addr = (state_reg == L_RING0) ? i1 : i2;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        rd_reg <= ring_mem[rd_addr];
    end

    // multiplier operands, end state of the old segment at u = 1
    always_comb begin
        if (hor_reg) begin
            mul_w = {1'b0, (end_reg ? ONE_U : u)};
        end else if (ph_reg == PH_VEL || ph_reg == PH_ACC) begin
            mul_w = inv_seg_time;
        end else begin
            mul_w = seg_time;
        end
        phi = 65'(signed'(acc_reg[47:16])) * 65'(signed'({1'b0, mul_w}));
    end

    always_ff @(posedge aclk) begin
        if (state_reg == L_MUL_LO) begin
            plo_reg <= 48'(acc_reg[15:0]) * 48'(mul_w);
        end
        if (state_reg == L_MUL_HI) begin
            prod_reg <= (80'(phi) <<< 16) + signed'({32'b0, plo_reg});
        end
    end

    // horner term and product post processing
    always_comb begin
        kidx = (state_reg == L_INIT) ? horner_top(ph_reg) : idx_reg;
        cidx = kidx + coef_offset(ph_reg);
        kval = scale_coef(coef_reg[cidx], coef_factor(ph_reg, kidx));
        if (hor_reg) begin
            shv = prod_reg >>> U_FRAC;
        end else if (ph_reg == PH_VEL || ph_reg == PH_ACC) begin
            shv = prod_reg >>> INV_FRAC;
        end else begin
            shv = prod_reg >>> SEG_FRAC;
        end
        shs      = sat48(shv);
        post_val = hor_reg ? sat48(80'(shs) + 80'(kval)) : shs;
    end

    // segment build terms
    always_comb begin
        s0x   = 80'(p_reg);
        dx    = 80'(d_reg);
        ddx   = 80'(dd_reg);
        diffx = 80'(s2_reg) - s0x;
        ex    = s0x - 80'(se_reg);
        b5    = (-ddx - dx * 80'sd6 - diffx * 80'sd3 - ex * 80'sd12) >>> 1;
        b4    = (ddx * 80'sd3 + dx * 80'sd16 + diffx * 80'sd7 + ex * 80'sd30) >>> 1;
        b3    = (-(ddx * 80'sd3) - dx * 80'sd12 - diffx * 80'sd4 - ex * 80'sd20) >>> 1;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE: begin
                if (ctrl.start) begin
                    state_next = ctrl.new_seg ? L_RING0 : L_INIT;
                end
            end
            L_RING0:  state_next = L_RING1;
            L_RING1:  state_next = L_RING2;
            L_RING2:  state_next = L_INIT;
            L_INIT:   state_next = L_MUL_LO;
            L_MUL_LO: state_next = L_MUL_HI;
            L_MUL_HI: state_next = L_POST;
            L_POST: begin
                if (hor_reg) begin
                    if (idx_reg != 3'd0) begin
                        state_next = L_MUL_LO;
                    end else if (ph_reg == PH_POS) begin
                        state_next = L_INIT;
                    end else begin
                        state_next = L_MUL_LO;
                    end
                end else begin
                    case (ph_reg)
                        PH_VEL: state_next = L_INIT;
                        PH_ACC: begin
                            if (!scnt_reg) begin
                                state_next = L_MUL_LO;
                            end else if (end_reg) begin
                                state_next = L_INIT;
                            end else begin
                                state_next = L_IDLE;
                            end
                        end
                        PH_D:    state_next = L_INIT;
                        PH_T:    state_next = L_MUL_LO;
                        PH_DD:   state_next = L_BUILD5;
                        default: state_next = L_IDLE;
                    endcase
                end
            end
            L_BUILD5: state_next = L_BUILD4;
            L_BUILD4: state_next = L_BUILD3;
            L_BUILD3: state_next = L_INIT;
            default:  state_next = L_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        ph_next   = ph_reg;
        hor_next  = hor_reg;
        scnt_next = scnt_reg;
        end_next  = end_reg;
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        p_next    = p_reg;
        v_next    = v_reg;
        a_next    = a_reg;
        d_next    = d_reg;
        dd_next   = dd_reg;
        se_next   = se_reg;
        s2_next   = s2_reg;
        for (int i = 0; i < 6; i++) begin
            coef_next[i] = coef_reg[i];
        end
        case (state_reg)
            L_IDLE: begin
                if (ctrl.start) begin
                    ph_next  = PH_POS;
                    end_next = ctrl.new_seg;
                end
            end
            L_RING1: se_next = ctrl.have ? signed'(rd_reg) : 32'sd0;
            L_RING2: s2_next = ctrl.have ? signed'(rd_reg) : 32'sd0;
            L_INIT: begin
                scnt_next = 1'b0;
                case (ph_reg)
                    PH_D: begin
                        acc_next = v_reg;
                        hor_next = 1'b0;
                    end
                    PH_T: begin
                        acc_next = a_reg;
                        hor_next = 1'b0;
                    end
                    default: begin
                        acc_next = kval;
                        hor_next = 1'b1;
                        idx_next = horner_top(ph_reg) - 3'd1;
                    end
                endcase
            end
            L_POST: begin
                acc_next = post_val;
                if (hor_reg) begin
                    if (idx_reg != 3'd0) begin
                        idx_next = idx_reg - 3'd1;
                    end else if (ph_reg == PH_POS) begin
                        p_next  = post_val;
                        ph_next = PH_VEL;
                    end else begin
                        hor_next = 1'b0;
                    end
                end else begin
                    case (ph_reg)
                        PH_VEL: begin
                            v_next  = post_val;
                            ph_next = PH_ACC;
                        end
                        PH_ACC: begin
                            if (!scnt_reg) begin
                                scnt_next = 1'b1;
                            end else begin
                                a_next = post_val;
                                if (end_reg) begin
                                    ph_next = PH_D;
                                end
                            end
                        end
                        PH_D: begin
                            d_next  = post_val;
                            ph_next = PH_T;
                        end
                        PH_T:    ph_next = PH_DD;
                        PH_DD:   dd_next = post_val;
                        default: ph_next = ph_reg;
                    endcase
                end
            end
            L_BUILD5: coef_next[5] = sat48(b5);
            L_BUILD4: coef_next[4] = sat48(b4);
            L_BUILD3: begin
                coef_next[3] = sat48(b3);
                coef_next[2] = dd_reg >>> 1;
                coef_next[1] = d_reg;
                coef_next[0] = p_reg;
                end_next     = 1'b0;
                ph_next      = PH_POS;
            end
            default: ph_next = ph_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            ph_reg    <= PH_POS;
            hor_reg   <= 1'b0;
            scnt_reg  <= 1'b0;
            end_reg   <= 1'b0;
            idx_reg   <= 3'd0;
            for (int i = 0; i < 6; i++) begin
                coef_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            hor_reg   <= hor_next;
            scnt_reg  <= scnt_next;
            end_reg   <= end_next;
            idx_reg   <= idx_next;
            for (int i = 0; i < 6; i++) begin
                coef_reg[i] <= coef_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        p_reg   <= p_next;
        v_reg   <= v_next;
        a_reg   <= a_next;
        d_reg   <= d_next;
        dd_reg  <= dd_next;
        se_reg  <= se_next;
        s2_reg  <= s2_next;
    end

    assign idle = (state_reg == L_IDLE);
    assign pos  = p_reg;
    assign vel  = v_reg;
    assign acc  = a_reg;

endmodule

@@ src/quintic_trajectory_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// quintic_trajectory_interpolator_top
// three-axis quintic trajectory interpolator with waypoint ring
//
// input words (s_*): mode 0 pushes a waypoint into the ring and yields no
// result; a push into a full ring is dropped. mode 1 is a time tick and
// yields one result word (m_*) with position, velocity and acceleration per
// axis and segment_start.
// config words (cfg_*): always ready, index selects seg_ticks, seg_time,
// inv_seg_time or tick_time; write only while no tick is in flight.
// each axis lane owns one 48x32 multiplier, and the horner chains run
// through it one step at a time. one tick is worked at a time; the next
// word is taken in the cycle after the result loads.
// reset: ring empty, counters and coefficients zero, registers at defaults.
// a stalled m_ready holds the result word; a finished tick then waits in
// the lanes until the output register frees.
// ----------------------------------------------------------------------------
module quintic_trajectory_interpolator_top
    import qti_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int AXES       = AXES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_way_x,
    input  logic [31:0] s_way_y,
    input  logic [31:0] s_way_z,
    output logic        m_valid,
    input  logic        m_ready,
    output q48_t        m_pos_x,
    output q48_t        m_vel_x,
    output q48_t        m_acc_x,
    output q48_t        m_pos_y,
    output q48_t        m_vel_y,
    output q48_t        m_acc_y,
    output q48_t        m_pos_z,
    output q48_t        m_vel_z,
    output q48_t        m_acc_z,
    output logic        m_segment_start
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    top_state_t state_reg, state_next;

    logic [11:0] seg_ticks_reg, seg_ticks_next;
    logic [31:0] seg_time_reg, seg_time_next;
    logic [31:0] inv_reg, inv_next;
    logic [31:0] tick_time_reg, tick_time_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] ri_reg, ri_next;
    logic [11:0]      tc_reg, tc_next;
    logic [11:0]      tce_reg, tce_next;
    logic [IDX_W-1:0] i1_reg, i1_next;
    logic [IDX_W-1:0] i2_reg, i2_next;
    logic             have_reg, have_next;
    logic             nseg_reg, nseg_next;
    logic [45:0]      step_reg;
    logic [30:0]      u_reg;
    logic             m_valid_reg, m_valid_next;
    logic             mseg_reg;

    logic [11:0]      st;
    logic             push_acc, tick_acc, full, new_seg;
    logic [CNT_W-1:0] i1w, i1m, i2w, i2m;
    logic [63:0]      step_prod;
    logic [42:0]      u_prod;
    logic [30:0]      u_val;
    logic             load;
    logic             lanes_idle;

    lane_ctrl_t  ctrl;
    logic [31:0] way_data [3];
    q48_t        lane_pos [3];
    q48_t        lane_vel [3];
    q48_t        lane_acc [3];
    logic [2:0]  lane_idle;
    q48_t        out_pos_reg [3];
    q48_t        out_vel_reg [3];
    q48_t        out_acc_reg [3];

    assign way_data[0] = s_way_x;
    assign way_data[1] = s_way_y;
    assign way_data[2] = s_way_z;

    assign cfg_ready  = 1'b1;
    assign st         = (seg_ticks_reg == 12'd0) ? 12'd1 : seg_ticks_reg;
    assign push_acc   = s_valid && s_ready && (s_mode == MODE_PUSH);
    assign tick_acc   = s_valid && s_ready && (s_mode == MODE_TICK);
    assign full       = (count_reg == CNT_W'(RING_DEPTH));
    assign new_seg    = (tc_reg >= st);
    assign lanes_idle = &lane_idle;

    // next ring indices, read index always below the fill count
    always_comb begin
        i1w = CNT_W'(ri_reg) + CNT_W'(1);
        i1m = (i1w >= count_reg) ? i1w - count_reg : i1w;
        i2w = i1m + CNT_W'(1);
        i2m = (i2w >= count_reg) ? i2w - count_reg : i2w;
    end

    // segment time step and clamped u
    assign step_prod = 64'(tick_time_reg) * 64'(inv_reg);
    assign u_prod    = 43'(tce_reg) * 43'(step_reg[30:0]);

    always_comb begin
        if (step_reg > 46'(ONE_U)) begin
            u_val = (tce_reg == 12'd0) ? 31'd0 : ONE_U;
        end else if (u_prod > 43'(ONE_U)) begin
            u_val = ONE_U;
        end else begin
            u_val = u_prod[30:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: begin
                if (tick_acc) begin
                    state_next = T_STEP;
                end
            end
            T_STEP:  state_next = T_U;
            T_U:     state_next = T_START;
            T_START: state_next = T_WAIT;
            T_WAIT: begin
                if (load) begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready       = (state_reg == T_IDLE);
        load          = (state_reg == T_WAIT) && lanes_idle && (!m_valid_reg || m_ready);
        ctrl.start    = (state_reg == T_START);
        ctrl.new_seg  = nseg_reg;
        ctrl.have     = have_reg;
        ctrl.wr_en    = push_acc && !full;
    end

    // register updates
    always_comb begin
        seg_ticks_next = seg_ticks_reg;
        seg_time_next  = seg_time_reg;
        inv_next       = inv_reg;
        tick_time_next = tick_time_reg;
        count_next     = count_reg;
        ri_next        = ri_reg;
        tc_next        = tc_reg;
        tce_next       = tce_reg;
        i1_next        = i1_reg;
        i2_next        = i2_reg;
        have_next      = have_reg;
        nseg_next      = nseg_reg;
        m_valid_next   = m_valid_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SEG_TICKS:    seg_ticks_next = cfg_data[11:0];
                CFG_SEG_TIME:     seg_time_next  = cfg_data;
                CFG_INV_SEG_TIME: inv_next       = cfg_data;
                CFG_TICK_TIME:    tick_time_next = cfg_data;
                default:          seg_ticks_next = seg_ticks_reg;
            endcase
        end

        if (push_acc && !full) begin
            count_next = count_reg + CNT_W'(1);
        end

        if (tick_acc) begin
            nseg_next = new_seg;
            have_next = (count_reg != '0);
            i1_next   = i1m[IDX_W-1:0];
            i2_next   = i2m[IDX_W-1:0];
            if (new_seg) begin
                tce_next = 12'd0;
                tc_next  = 12'd1;
                ri_next  = (count_reg != '0) ? i1m[IDX_W-1:0] : '0;
            end else begin
                tce_next = tc_reg;
                tc_next  = tc_reg + 12'd1;
            end
        end

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            seg_ticks_reg <= SEG_TICKS_RST;
            seg_time_reg  <= SEG_TIME_RST;
            inv_reg       <= INV_SEG_TIME_RST;
            tick_time_reg <= TICK_TIME_RST;
            count_reg     <= '0;
            ri_reg        <= '0;
            tc_reg        <= 12'd0;
            have_reg      <= 1'b0;
            nseg_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seg_ticks_reg <= seg_ticks_next;
            seg_time_reg  <= seg_time_next;
            inv_reg       <= inv_next;
            tick_time_reg <= tick_time_next;
            count_reg     <= count_next;
            ri_reg        <= ri_next;
            tc_reg        <= tc_next;
            have_reg      <= have_next;
            nseg_reg      <= nseg_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tce_reg <= tce_next;
        i1_reg  <= i1_next;
        i2_reg  <= i2_next;
        if (state_reg == T_STEP) begin
            step_reg <= step_prod[63:STEP_SHIFT];
        end
        if (state_reg == T_U) begin
            u_reg <= u_val;
        end
        if (load) begin
            mseg_reg <= nseg_reg;
            for (int a = 0; a < 3; a++) begin
                out_pos_reg[a] <= lane_pos[a];
                out_vel_reg[a] <= lane_vel[a];
                out_acc_reg[a] <= lane_acc[a];
            end
        end
    end

    // axis lanes
    for (genvar a = 0; a < 3; a++) begin : g_axis
        if (a < AXES) begin : g_lane
            qti_lane #(
                .RING_DEPTH(RING_DEPTH)
            ) u_lane (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctrl         (ctrl),
                .wr_addr      (count_reg[IDX_W-1:0]),
                .wr_data      (way_data[a]),
                .i1           (i1_reg),
                .i2           (i2_reg),
                .u            (u_reg),
                .seg_time     (seg_time_reg),
                .inv_seg_time (inv_reg),
                .idle         (lane_idle[a]),
                .pos          (lane_pos[a]),
                .vel          (lane_vel[a]),
                .acc          (lane_acc[a])
            );
        end else begin : g_none
            assign lane_idle[a] = 1'b1;
            assign lane_pos[a]  = '0;
            assign lane_vel[a]  = '0;
            assign lane_acc[a]  = '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_segment_start = mseg_reg;
    assign m_pos_x         = out_pos_reg[0];
    assign m_vel_x         = out_vel_reg[0];
    assign m_acc_x         = out_acc_reg[0];
    assign m_pos_y         = out_pos_reg[1];
    assign m_vel_y         = out_vel_reg[1];
    assign m_acc_y         = out_acc_reg[1];
    assign m_pos_z         = out_pos_reg[2];
    assign m_vel_z         = out_vel_reg[2];
    assign m_acc_z         = out_acc_reg[2];

`include "quintic_trajectory_interpolator_top_assert.svh"

    `QTI_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(RING_DEPTH))
    `QTI_ASSERT_NOW(a_index_below_count, count_reg != '0, CNT_W'(ri_reg) < count_reg)
    `QTI_ASSERT_NEXT(a_full_push_dropped, push_acc && full, $stable(count_reg))
    `QTI_ASSERT_NEXT(a_tick_advances, tick_acc, tc_reg != 12'd0)
    `QTI_ASSERT_NEXT(a_result_loaded, load, m_valid_reg)

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic trajectory interpolator testbench
// directed rows, then random waypoint pushes and ticks under several
// register settings; every tick result is checked against a fixed point
// model of the interpolator kept in this file
// ----------------------------------------------------------------------------
module testbench;
    import qti_pkg::*;

    localparam int  WATCH_LIMIT = 4000;
    localparam int  SETTLE      = 200;
    localparam longint LIM_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LIM_LO   = -64'sh0000_8000_0000_0000;
    localparam longint U_ONE    = 64'sh4000_0000;

    typedef struct {
        logic [47:0] f[9];
        logic        start;
    } motion_t;

    typedef struct {
        logic        mode;
        logic [31:0] x, y, z;
        logic        typed;
    } stim_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    logic s_mode = 0;
    logic [31:0] s_way_x = '0, s_way_y = '0, s_way_z = '0;
    logic m_valid;
    logic m_ready = 0;
    q48_t m_pos_x, m_vel_x, m_acc_x, m_pos_y, m_vel_y, m_acc_y;
    q48_t m_pos_z, m_vel_z, m_acc_z;
    logic m_segment_start;

    quintic_trajectory_interpolator_top uut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // model state
    logic [31:0] ring [3][256];
    int          wp_count, rd_idx, tick_cnt;
    longint      st_pos[3], st_vel[3], st_acc[3];
    longint      coef[18];
    logic [11:0] r_seg_ticks = SEG_TICKS_RST;
    logic [31:0] r_seg_time = SEG_TIME_RST;
    logic [31:0] r_inv_time = INV_SEG_TIME_RST;
    logic [31:0] r_tick_time = TICK_TIME_RST;

    motion_t motion_q[$];
    bit      fault = 0;
    int      idle_cycles = 0;
    string   fnames[9] = '{"pos_x", "vel_x", "acc_x", "pos_y", "vel_y", "acc_y",
                           "pos_z", "vel_z", "acc_z"};

    function automatic longint clamp48(longint v);
        return v > LIM_HI ? LIM_HI : (v < LIM_LO ? LIM_LO : v);
    endfunction

    function automatic longint scaled(longint a, longint w, int n);
        logic signed [95:0] p;
        p = 96'(a) * 96'(w);
        return longint'(p >>> n);
    endfunction

    function automatic longint horner(longint k[6], int deg, longint u);
        longint acc;
        acc = k[deg];
        for (int i = deg - 1; i >= 0; i--)
            acc = clamp48(clamp48(scaled(acc, u, 30)) + k[i]);
        return acc;
    endfunction

    task automatic eval_axis(int a, longint u, output longint p, output longint v,
                             output longint ac);
        longint c[6], k1[6], k2[6], t, inv;
        inv = longint'(r_inv_time);
        for (int i = 0; i < 6; i++) begin
            c[i] = coef[a*6 + i];
            k1[i] = 0;
            k2[i] = 0;
        end
        k1[0] = c[1];
        k1[1] = clamp48(2 * c[2]);
        k1[2] = clamp48(3 * c[3]);
        k1[3] = clamp48(4 * c[4]);
        k1[4] = clamp48(5 * c[5]);
        k2[0] = clamp48(2 * c[2]);
        k2[1] = clamp48(6 * c[3]);
        k2[2] = clamp48(12 * c[4]);
        k2[3] = clamp48(20 * c[5]);
        p = horner(c, 5, u);
        v = clamp48(scaled(horner(k1, 4, u), inv, 16));
        t = clamp48(scaled(horner(k2, 3, u), inv, 16));
        ac = clamp48(scaled(t, inv, 16));
    endtask

    task automatic build_axis(int a, longint s_end, longint s_next2);
        longint s0, d, dd, diff, e, segt;
        segt = longint'(r_seg_time);
        s0 = st_pos[a];
        d = clamp48(scaled(st_vel[a], segt, 32));
        dd = clamp48(scaled(clamp48(scaled(st_acc[a], segt, 32)), segt, 32));
        diff = s_next2 - s0;
        e = s0 - s_end;
        coef[a*6 + 5] = clamp48((-dd - 6*d - 3*diff - 12*e) >>> 1);
        coef[a*6 + 4] = clamp48((3*dd + 16*d + 7*diff + 30*e) >>> 1);
        coef[a*6 + 3] = clamp48((-3*dd - 12*d - 4*diff - 20*e) >>> 1);
        coef[a*6 + 2] = dd >>> 1;
        coef[a*6 + 1] = d;
        coef[a*6 + 0] = s0;
    endtask

    // advances the model by one accepted word; returns 1 with the motion on ticks
    task automatic trajectory_step(logic mode, logic [31:0] x, logic [31:0] y,
                                   logic [31:0] z, output bit has, output motion_t m);
        int st, i1, i2;
        bit have;
        longint u, step, p, v, ac;
        longint unsigned prod;
        has = 0;
        m.start = 0;
        if (mode == MODE_PUSH) begin
            if (wp_count < 256) begin
                ring[0][wp_count] = x;
                ring[1][wp_count] = y;
                ring[2][wp_count] = z;
                wp_count++;
            end
            return;
        end
        st = (r_seg_ticks == 0) ? 1 : int'(r_seg_ticks);
        if (tick_cnt >= st) begin
            have = wp_count > 0;
            i1 = have ? (rd_idx + 1) % wp_count : 0;
            i2 = have ? (rd_idx + 2) % wp_count : 0;
            for (int a = 0; a < 3; a++) begin
                eval_axis(a, U_ONE, st_pos[a], st_vel[a], st_acc[a]);
                build_axis(a, have ? longint'($signed(ring[a][i1])) : 0,
                           have ? longint'($signed(ring[a][i2])) : 0);
            end
            rd_idx = have ? (rd_idx + 1) % wp_count : 0;
            tick_cnt = 0;
            m.start = 1;
        end
        prod = longint'(r_tick_time) * longint'(r_inv_time);
        step = longint'(prod >> STEP_SHIFT);
        u = longint'(tick_cnt) * step;
        if (u > U_ONE) u = U_ONE;
        for (int a = 0; a < 3; a++) begin
            eval_axis(a, u, p, v, ac);
            st_pos[a] = p;
            st_vel[a] = v;
            st_acc[a] = ac;
            m.f[a*3] = p[47:0];
            m.f[a*3 + 1] = v[47:0];
            m.f[a*3 + 2] = ac[47:0];
        end
        tick_cnt = (tick_cnt + 1) & 12'hFFF;
        has = 1;
    endtask

    task automatic send_word(logic mode, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             bit typed);
        bit has;
        motion_t m;
        s_valid <= 1;
        s_mode <= mode;
        s_way_x <= x;
        s_way_y <= y;
        s_way_z <= z;
        do @(posedge aclk); while (!s_ready);
        trajectory_step(mode, x, y, z, has, m);
        if (has) begin
            if (typed) begin
                foreach (m.f[i]) m.f[i] = '0;
                m.start = 0;
            end
            motion_q = {motion_q, m};
        end
    endtask

    task automatic sender_gap();
        int g;
        if ($urandom_range(0, 3) == 0) begin
            g = $urandom_range(1, 30);
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        while (motion_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SEG_TICKS:    r_seg_ticks = val[11:0];
            CFG_SEG_TIME:     r_seg_time = val;
            CFG_INV_SEG_TIME: r_inv_time = val;
            CFG_TICK_TIME:    r_tick_time = val;
            default:          r_seg_ticks = r_seg_ticks;
        endcase
    endtask

    task automatic set_regs(logic [31:0] ticks, logic [31:0] segt, logic [31:0] inv,
                            logic [31:0] tickt);
        drain();
        cfg_write(CFG_SEG_TICKS, ticks);
        cfg_write(CFG_SEG_TIME, segt);
        cfg_write(CFG_INV_SEG_TIME, inv);
        cfg_write(CFG_TICK_TIME, tickt);
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] rand_way();
        if ($urandom_range(0, 4) == 0) return $urandom();
        return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
    endfunction

    task automatic random_words(int n);
        for (int i = 0; i < n; i++) begin
            send_word($urandom_range(0, 3) == 0 ? MODE_PUSH : MODE_TICK,
                      rand_way(), rand_way(), rand_way(), 0);
            if (i % 40 < 25) sender_gap();
        end
    endtask

    stim_row_t stim_rows[] = '{
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 1},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_PUSH, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0},
        '{MODE_PUSH, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0},
        '{MODE_PUSH, 32'h0100_0000, 32'hFF00_0000, 32'h0000_0001, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0},
        '{MODE_PUSH, 32'h0200_0000, 32'h0300_0000, 32'hFC00_0000, 0},
        '{MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0},
        '{MODE_TICK, 32'h0, 32'h0, 32'h0, 0}
    };

    // result checking and receiver stall pattern
    int rx_cycle = 0;
    always @(posedge aclk) begin
        logic [47:0] got[9];
        motion_t want;
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 3)
            0: m_ready <= 1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 4) == 0);
        endcase
        if (aresetn && m_valid && m_ready) begin
            got = '{m_pos_x, m_vel_x, m_acc_x, m_pos_y, m_vel_y, m_acc_y,
                    m_pos_z, m_vel_z, m_acc_z};
            if (motion_q.size() == 0) begin
                $error("result word with nothing expected");
                fault = 1;
            end else begin
                want = motion_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.f[i]) begin
                        $error("%s expected %h got %h", fnames[i], want.f[i], got[i]);
                        fault = 1;
                    end
                if (m_segment_start !== want.start) begin
                    $error("segment_start expected %b got %b", want.start, m_segment_start);
                    fault = 1;
                end
            end
        end
    end

    // watchdog on cycles with no accepted word anywhere
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        wp_count = 0;
        rd_idx = 0;
        tick_cnt = 0;
        foreach (coef[i]) coef[i] = 0;
        for (int a = 0; a < 3; a++) begin
            st_pos[a] = 0;
            st_vel[a] = 0;
            st_acc[a] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            send_word(stim_rows[i].mode, stim_rows[i].x, stim_rows[i].y, stim_rows[i].z,
                      stim_rows[i].typed);
            if (i % 5 == 4) sender_gap();
        end
        random_words(200);

        // sender holds until every result is back
        drain();
        random_words(50);

        set_regs(32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        random_words(250);
        set_regs(32'd5, 32'd429496730, 32'd655360, 32'd85899346);
        random_words(300);
        set_regs(32'd4095, 32'd1, 32'hFFFF_FFFF, 32'd1);
        random_words(200);
        set_regs(32'd7, 32'd21474837, 32'd13107200, 32'd2147484);
        random_words(300);
        set_regs(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_words(150);
        set_regs($urandom_range(1, 12), $urandom_range(1, 32'hFFFF_FFFF),
                 $urandom_range(1, 32'h00FF_FFFF), $urandom_range(1, 32'h0FFF_FFFF));
        random_words(300);

        drain();
        if (!fault)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
